// ===== src/amc_pkg.sv =====
// Shared types and constants for the airborne mode controller.
`default_nettype none

package amc_pkg;

   typedef enum logic [1:0] {
      MODE_GROUND  = 2'd0,
      MODE_AIR     = 2'd1,
      MODE_LAND    = 2'd2,
      MODE_RECOVER = 2'd3
   } mode_type;

   // Function codes carried in the request
   localparam logic FUNC_UPDATE  = 1'b0;
   localparam logic FUNC_COMMAND = 1'b1;

   // Register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AIR_PITCH_GAIN  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AIR_ROLL_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAND_PITCH_GAIN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAND_ROLL_GAIN  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LANDING_HOLD    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETTLE_HOLD     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CONF_THRESHOLD  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRAVITY_LEVEL   = 3'd7;

   // Register reset values
   localparam logic [15:0] RST_AIR_PITCH_GAIN  = 16'd1229;
   localparam logic [15:0] RST_AIR_ROLL_GAIN   = 16'd410;
   localparam logic [15:0] RST_LAND_PITCH_GAIN = 16'd3277;
   localparam logic [15:0] RST_LAND_ROLL_GAIN  = 16'd1229;
   localparam logic [15:0] RST_LANDING_HOLD    = 16'd200;
   localparam logic [15:0] RST_SETTLE_HOLD     = 16'd300;
   localparam logic [15:0] RST_CONF_THRESHOLD  = 16'd45875;
   localparam logic [15:0] RST_GRAVITY_LEVEL   = 16'd2511;

   // Throttle commands, Q1.14
   localparam logic signed [15:0] THROTTLE_AIR  = 16'sd4915;
   localparam logic signed [15:0] THROTTLE_LAND = -16'sd8192;
   localparam logic signed [15:0] THROTTLE_NONE = 16'sd0;

   typedef struct packed {
      logic [15:0] air_pitch_gain;
      logic [15:0] air_roll_gain;
      logic [15:0] land_pitch_gain;
      logic [15:0] land_roll_gain;
      logic [15:0] landing_hold_ms;
      logic [15:0] settle_hold_ms;
      logic [15:0] confidence_threshold;
      logic [15:0] gravity_level;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic [31:0]        stamp_ms;
      logic               airborne_flag;
      logic [15:0]        confidence;
      logic               impact_flag;
      logic [15:0]        peak_impact;
      logic signed [15:0] pitch_error;
      logic signed [15:0] roll_error;
      logic signed [15:0] balance_pitch;
      logic signed [15:0] balance_roll;
   } req_type;

   typedef struct packed {
      logic [1:0]         flight_mode;
      logic signed [15:0] pitch_cmd;
      logic signed [15:0] roll_cmd;
      logic signed [15:0] throttle_cmd;
      logic               takeoff_pulse;
      logic               landing_pulse;
      logic [31:0]        total_airborne_ms;
      logic [31:0]        longest_airborne_ms;
      logic [31:0]        hard_landing_count;
      logic [31:0]        good_landing_count;
   } rsp_type;

   // Mode core status toward the result register
   typedef struct packed {
      mode_type    mode;
      logic        takeoff_pulse;
      logic        landing_pulse;
      logic [31:0] total_airborne_ms;
      logic [31:0] longest_airborne_ms;
      logic [31:0] hard_landing_count;
      logic [31:0] good_landing_count;
   } status_type;

   // Actuator commands toward the result register
   typedef struct packed {
      logic signed [15:0] pitch_cmd;
      logic signed [15:0] roll_cmd;
      logic signed [15:0] throttle_cmd;
   } cmd_type;

endpackage

`default_nettype wire

// ===== src/amc_mode_core.sv =====
// Mode state machine with airborne time and landing statistics.
`default_nettype none

module amc_mode_core #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire amc_pkg::req_type    item,
   input  wire amc_pkg::cfg_type    cfg,
   output amc_pkg::mode_type        mode_now,
   output amc_pkg::status_type      status
);

   localparam int unsigned REPORT_WIDTH = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

   amc_pkg::mode_type mode_ff, mode_in;
   logic [31:0] entry_ff, entry_in;
   logic [31:0] takeoff_ff, takeoff_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] peak_ff, peak_in;
   logic [COUNT_WIDTH-1:0] hard_ff, hard_in;
   logic [COUNT_WIDTH-1:0] good_ff, good_in;

   logic        is_update;
   logic [31:0] elapsed;
   logic [31:0] air_time;
   logic        hard_hit;
   logic        take_pulse;
   logic        land_pulse;

   assign is_update = (item.func == amc_pkg::FUNC_UPDATE);
   assign elapsed   = item.stamp_ms - entry_ff;
   assign air_time  = item.stamp_ms - takeoff_ff;
   assign hard_hit  = {1'b0, item.peak_impact} > {cfg.gravity_level, 1'b0};

   // Next state
   always_comb begin
      mode_in = mode_ff;
      if (is_update) begin
         case (mode_ff)
            amc_pkg::MODE_GROUND: begin
               if (item.airborne_flag && (item.confidence > cfg.confidence_threshold)) begin
                  mode_in = amc_pkg::MODE_AIR;
               end
            end
            amc_pkg::MODE_AIR: begin
               if (!item.airborne_flag || item.impact_flag) begin
                  mode_in = amc_pkg::MODE_LAND;
               end
            end
            amc_pkg::MODE_LAND: begin
               if (elapsed > {16'd0, cfg.landing_hold_ms}) begin
                  mode_in = amc_pkg::MODE_RECOVER;
               end
            end
            amc_pkg::MODE_RECOVER: begin
               if (elapsed > {16'd0, cfg.settle_hold_ms}) begin
                  mode_in = amc_pkg::MODE_GROUND;
               end
            end
            default: begin
               mode_in = amc_pkg::MODE_GROUND;
            end
         endcase
      end
   end

   // Outputs of each transition
   always_comb begin
      entry_in   = entry_ff;
      takeoff_in = takeoff_ff;
      sum_in     = sum_ff;
      peak_in    = peak_ff;
      hard_in    = hard_ff;
      good_in    = good_ff;
      take_pulse = 1'b0;
      land_pulse = 1'b0;
      if (mode_ff == amc_pkg::MODE_GROUND && mode_in == amc_pkg::MODE_AIR) begin
         take_pulse = 1'b1;
         entry_in   = item.stamp_ms;
         takeoff_in = item.stamp_ms;
      end
      if (mode_ff == amc_pkg::MODE_AIR && mode_in == amc_pkg::MODE_LAND) begin
         land_pulse = 1'b1;
         entry_in   = item.stamp_ms;
         sum_in     = sum_ff + air_time;
         if (air_time > peak_ff) begin
            peak_in = air_time;
         end
      end
      if (mode_ff == amc_pkg::MODE_LAND && mode_in == amc_pkg::MODE_RECOVER) begin
         entry_in = item.stamp_ms;
         if (hard_hit) begin
            hard_in = hard_ff + COUNT_WIDTH'(1);
         end else begin
            good_in = good_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= amc_pkg::MODE_GROUND;
         entry_ff   <= '0;
         takeoff_ff <= '0;
         sum_ff     <= '0;
         peak_ff    <= '0;
         hard_ff    <= '0;
         good_ff    <= '0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         entry_ff   <= entry_in;
         takeoff_ff <= takeoff_in;
         sum_ff     <= sum_in;
         peak_ff    <= peak_in;
         hard_ff    <= hard_in;
         good_ff    <= good_in;
      end
   end

   assign mode_now = mode_ff;

   // Report the low bits of the counters, zero extended when narrow
   always_comb begin
      status                     = '0;
      status.mode                = mode_in;
      status.takeoff_pulse       = take_pulse;
      status.landing_pulse       = land_pulse;
      status.total_airborne_ms   = sum_in;
      status.longest_airborne_ms = peak_in;
      status.hard_landing_count[REPORT_WIDTH-1:0] = hard_in[REPORT_WIDTH-1:0];
      status.good_landing_count[REPORT_WIDTH-1:0] = good_in[REPORT_WIDTH-1:0];
   end

`ifndef NO_ASSERTIONS
   a_single_pulse : assert property (@(posedge clock) disable iff (reset)
      !(take_pulse && land_pulse))
      else $error("takeoff and landing in one update");

   a_takeoff_stamp : assert property (@(posedge clock) disable iff (reset)
      fire && take_pulse |=> mode_ff == amc_pkg::MODE_AIR && takeoff_ff == entry_ff)
      else $error("takeoff did not record its timestamp");

   a_command_holds : assert property (@(posedge clock) disable iff (reset)
      fire && item.func == amc_pkg::FUNC_COMMAND |=> $stable(mode_ff) && $stable(sum_ff))
      else $error("command transaction changed mode state");
`endif

endmodule

`default_nettype wire

// ===== src/amc_cmd_gen.sv =====
// Pitch, roll and throttle command generation for the current mode.
`default_nettype none

module amc_cmd_gen (
   input  wire amc_pkg::mode_type mode,
   input  wire amc_pkg::req_type  item,
   input  wire amc_pkg::cfg_type  cfg,
   output amc_pkg::cmd_type       cmd
);

   // Q4.12 gain times Q1.14 error, rounded to Q1.14 and saturated
   function automatic logic signed [15:0] gain_mul(input logic [15:0] gain,
                                                   input logic signed [15:0] err);
      logic signed [32:0] prod;
      logic signed [33:0] rnd;
      logic signed [21:0] shifted;
      prod    = $signed({1'b0, gain}) * err;
      rnd     = {prod[32], prod} + 34'sd2048;
      shifted = rnd[33:12];
      if (shifted > 22'sd32767) begin
         return 16'sh7fff;
      end else if (shifted < -22'sd32768) begin
         return 16'sh8000;
      end
      return shifted[15:0];
   endfunction

   // Round half up, never leaves range
   function automatic logic signed [15:0] halve(input logic signed [15:0] b);
      logic signed [16:0] s;
      s = {b[15], b} + 17'sd1;
      return s[16:1];
   endfunction

   logic [15:0] pitch_gain;
   logic [15:0] roll_gain;
   logic signed [15:0] pitch_prod;
   logic signed [15:0] roll_prod;

   // One multiplier per axis, gain picked by mode
   assign pitch_gain = (mode == amc_pkg::MODE_LAND) ? cfg.land_pitch_gain : cfg.air_pitch_gain;
   assign roll_gain  = (mode == amc_pkg::MODE_LAND) ? cfg.land_roll_gain : cfg.air_roll_gain;
   assign pitch_prod = gain_mul(pitch_gain, item.pitch_error);
   assign roll_prod  = gain_mul(roll_gain, item.roll_error);

   always_comb begin
      cmd              = '0;
      cmd.throttle_cmd = amc_pkg::THROTTLE_NONE;
      if (item.func == amc_pkg::FUNC_COMMAND) begin
         case (mode)
            amc_pkg::MODE_GROUND: begin
               cmd.pitch_cmd = item.balance_pitch;
               cmd.roll_cmd  = item.balance_roll;
            end
            amc_pkg::MODE_AIR: begin
               cmd.pitch_cmd    = pitch_prod;
               cmd.roll_cmd     = roll_prod;
               cmd.throttle_cmd = amc_pkg::THROTTLE_AIR;
            end
            amc_pkg::MODE_LAND: begin
               cmd.pitch_cmd    = pitch_prod;
               cmd.roll_cmd     = roll_prod;
               cmd.throttle_cmd = amc_pkg::THROTTLE_LAND;
            end
            amc_pkg::MODE_RECOVER: begin
               cmd.pitch_cmd = halve(item.balance_pitch);
               cmd.roll_cmd  = halve(item.balance_roll);
            end
            default: begin
               cmd = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/airborne_mode_controller_unit.sv =====
// Top level of the airborne mode controller: registers, handshake and result assembly.
//
// Accepts one transaction per clock while the result side does not stall, and
// returns one result per transaction, in order. A transaction is held in the input
// register and then moves to the result register, where rsp_valid rises; sustained
// throughput is one transaction per cycle when the output is not stalled. That
// figure is set by the single pass from input register to result register: mode
// transition, airborne time add and compare, and two 17x16 gain multiplies with
// rounding and saturation. The input register can still take a transaction while a
// finished result waits to be taken, and it fills only when the result side stalls.
// An update transaction (func 0) advances the ground/airborne/landing/recovery
// machine and returns zero commands; a command transaction (func 1) leaves the state
// alone and returns commands for the current mode. Statistics in every result
// reflect the state after that transaction. There is no clearing pass after reset.
// Write the control registers only while idle.
`default_nettype none

module airborne_mode_controller_unit #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire amc_pkg::req_type                     req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output amc_pkg::rsp_type                          rsp_payload,
   input  wire logic                                 csr_we,
   input  wire logic [amc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [amc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   // Control registers
   amc_pkg::cfg_type cfg_ff;

   // Input register stage
   logic             in_valid_ff;
   amc_pkg::req_type in_ff;

   // Result register stage
   logic             out_valid_ff;
   amc_pkg::rsp_type out_ff;

   logic                in_advance;
   logic                req_accept;
   amc_pkg::mode_type   mode_now;
   amc_pkg::status_type status;
   amc_pkg::cmd_type    cmd;
   amc_pkg::rsp_type    result;

   // Advance the held transaction when the result slot is free or drains now
   assign in_advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || in_advance;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.air_pitch_gain       <= amc_pkg::RST_AIR_PITCH_GAIN;
         cfg_ff.air_roll_gain        <= amc_pkg::RST_AIR_ROLL_GAIN;
         cfg_ff.land_pitch_gain      <= amc_pkg::RST_LAND_PITCH_GAIN;
         cfg_ff.land_roll_gain       <= amc_pkg::RST_LAND_ROLL_GAIN;
         cfg_ff.landing_hold_ms      <= amc_pkg::RST_LANDING_HOLD;
         cfg_ff.settle_hold_ms       <= amc_pkg::RST_SETTLE_HOLD;
         cfg_ff.confidence_threshold <= amc_pkg::RST_CONF_THRESHOLD;
         cfg_ff.gravity_level        <= amc_pkg::RST_GRAVITY_LEVEL;
      end else if (csr_we) begin
         case (csr_index)
            amc_pkg::CSR_AIR_PITCH_GAIN:  cfg_ff.air_pitch_gain       <= csr_wdata;
            amc_pkg::CSR_AIR_ROLL_GAIN:   cfg_ff.air_roll_gain        <= csr_wdata;
            amc_pkg::CSR_LAND_PITCH_GAIN: cfg_ff.land_pitch_gain      <= csr_wdata;
            amc_pkg::CSR_LAND_ROLL_GAIN:  cfg_ff.land_roll_gain       <= csr_wdata;
            amc_pkg::CSR_LANDING_HOLD:    cfg_ff.landing_hold_ms      <= csr_wdata;
            amc_pkg::CSR_SETTLE_HOLD:     cfg_ff.settle_hold_ms       <= csr_wdata;
            amc_pkg::CSR_CONF_THRESHOLD:  cfg_ff.confidence_threshold <= csr_wdata;
            amc_pkg::CSR_GRAVITY_LEVEL:   cfg_ff.gravity_level        <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Input register: hold until the transaction moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_payload;
      end
   end

   amc_mode_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_mode_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (in_advance),
      .item     (in_ff),
      .cfg      (cfg_ff),
      .mode_now (mode_now),
      .status   (status)
   );

   // Commands use the mode before the transaction; command transactions never move it
   amc_cmd_gen u_cmd_gen (
      .mode (mode_now),
      .item (in_ff),
      .cfg  (cfg_ff),
      .cmd  (cmd)
   );

   always_comb begin
      result.flight_mode         = status.mode;
      result.pitch_cmd           = cmd.pitch_cmd;
      result.roll_cmd            = cmd.roll_cmd;
      result.throttle_cmd        = cmd.throttle_cmd;
      result.takeoff_pulse       = status.takeoff_pulse;
      result.landing_pulse       = status.landing_pulse;
      result.total_airborne_ms   = status.total_airborne_ms;
      result.longest_airborne_ms = status.longest_airborne_ms;
      result.hard_landing_count  = status.hard_landing_count;
      result.good_landing_count  = status.good_landing_count;
   end

   // Result register: load on advance, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (in_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_advance |-> !req_ready)
      else $error("input register would be overwritten");

   a_takeoff_mode : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.takeoff_pulse |->
         rsp_payload.flight_mode == amc_pkg::MODE_AIR && rsp_payload.throttle_cmd == 16'sd0)
      else $error("takeoff result not in airborne mode");

   a_landing_mode : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.landing_pulse |->
         rsp_payload.flight_mode == amc_pkg::MODE_LAND && !rsp_payload.takeoff_pulse)
      else $error("landing result not in landing mode");

   a_advance_loads : assert property (@(posedge clock) disable iff (reset)
      in_advance |=> rsp_valid)
      else $error("advanced transaction missing from result stage");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_airborne_mode_controller_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the airborne mode controller unit.
module tb_airborne_mode_controller_unit;

   // Watchdog limit. The slowest legal stretch without any transaction is the
   // receiver hold-off (HOLD_CYCLES) or a burst of register writes, so this
   // leaves a wide margin.
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 40;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned DRAIN_CYCLES = 10;

   // One row of the directed script: the request, and optionally a result
   // typed in by hand that replaces the predicted one.
   typedef struct {
      amc_pkg::req_type item;
      bit               pinned;
      amc_pkg::rsp_type pin;
   } script_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   amc_pkg::req_type                    req_payload;
   logic                                rsp_valid;
   logic                                rsp_ready;
   amc_pkg::rsp_type                    rsp_payload;
   logic                                csr_we;
   logic [amc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [amc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   airborne_mode_controller_unit #(
      .COUNT_WIDTH(32)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the control registers, indexed by register index.
   logic [15:0] knob [8];

   // Shadow copy of the mode machine and its statistics.
   amc_pkg::mode_type st_mode;
   logic [31:0]       st_entry_ms;
   logic [31:0]       st_takeoff_ms;
   logic [31:0]       st_air_total;
   logic [31:0]       st_air_longest;
   logic [31:0]       st_hard;
   logic [31:0]       st_good;

   // Results predicted for accepted transactions, oldest first.
   amc_pkg::rsp_type pending_results[$];

   // Hand-typed result traveling with the request on the bus.
   bit               pin_valid;
   amc_pkg::rsp_type pin_rsp;

   int unsigned accepted;
   int unsigned delivered;
   int unsigned mismatches;
   int unsigned quiet_cycles;
   int unsigned stall_cycles;
   int unsigned n_takeoffs;
   int unsigned n_landings;
   int unsigned n_commands;

   bit          calm;      // no idling on either side while set
   bit          hold_req;  // ask the receiver for one long hold-off
   logic [31:0] clock_ms;  // running timestamp for well-formed random traffic

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Q4.12 gain times Q1.14 error, rounded half up back to Q1.14, saturated.
   function automatic logic signed [15:0] scale_by_gain(logic [15:0] gain,
                                                        logic signed [15:0] err);
      longint prod;
      prod = (longint'(gain) * longint'(err) + 2048) >>> 12;
      if (prod > 32767)
         return 16'sh7FFF;
      if (prod < -32768)
         return 16'sh8000;
      return prod[15:0];
   endfunction

   // Halve with rounding half up; never leaves the 16-bit range.
   function automatic logic signed [15:0] halve_command(logic signed [15:0] b);
      longint h;
      h = (longint'(b) + 1) >>> 1;
      return h[15:0];
   endfunction

   // Apply one transaction to the shadow state and build the result it yields.
   function automatic amc_pkg::rsp_type advance_mode_machine(amc_pkg::req_type r);
      amc_pkg::rsp_type o;
      logic [31:0]      flight_ms;
      o = '0;
      if (r.func == amc_pkg::FUNC_UPDATE) begin
         case (st_mode)
            amc_pkg::MODE_GROUND: begin
               if (r.airborne_flag && r.confidence > knob[amc_pkg::CSR_CONF_THRESHOLD]) begin
                  st_mode         = amc_pkg::MODE_AIR;
                  st_entry_ms     = r.stamp_ms;
                  st_takeoff_ms   = r.stamp_ms;
                  o.takeoff_pulse = 1'b1;
                  n_takeoffs++;
               end
            end
            amc_pkg::MODE_AIR: begin
               if (!r.airborne_flag || r.impact_flag) begin
                  // Flight time wraps with the timestamp.
                  flight_ms       = r.stamp_ms - st_takeoff_ms;
                  st_mode         = amc_pkg::MODE_LAND;
                  st_entry_ms     = r.stamp_ms;
                  st_air_total    = st_air_total + flight_ms;
                  if (flight_ms > st_air_longest)
                     st_air_longest = flight_ms;
                  o.landing_pulse = 1'b1;
                  n_landings++;
               end
            end
            amc_pkg::MODE_LAND: begin
               if (r.stamp_ms - st_entry_ms > {16'd0, knob[amc_pkg::CSR_LANDING_HOLD]}) begin
                  st_mode     = amc_pkg::MODE_RECOVER;
                  st_entry_ms = r.stamp_ms;
                  // Grade against twice gravity at 17 bits so nothing overflows.
                  if ({1'b0, r.peak_impact} > {knob[amc_pkg::CSR_GRAVITY_LEVEL], 1'b0})
                     st_hard = st_hard + 1;
                  else
                     st_good = st_good + 1;
               end
            end
            default: begin
               // Leaving recovery keeps the old entry stamp.
               if (r.stamp_ms - st_entry_ms > {16'd0, knob[amc_pkg::CSR_SETTLE_HOLD]})
                  st_mode = amc_pkg::MODE_GROUND;
            end
         endcase
      end else begin
         n_commands++;
         case (st_mode)
            amc_pkg::MODE_GROUND: begin
               o.pitch_cmd = r.balance_pitch;
               o.roll_cmd  = r.balance_roll;
            end
            amc_pkg::MODE_AIR: begin
               o.pitch_cmd    = scale_by_gain(knob[amc_pkg::CSR_AIR_PITCH_GAIN],
                                              r.pitch_error);
               o.roll_cmd     = scale_by_gain(knob[amc_pkg::CSR_AIR_ROLL_GAIN],
                                              r.roll_error);
               o.throttle_cmd = amc_pkg::THROTTLE_AIR;
            end
            amc_pkg::MODE_LAND: begin
               o.pitch_cmd    = scale_by_gain(knob[amc_pkg::CSR_LAND_PITCH_GAIN],
                                              r.pitch_error);
               o.roll_cmd     = scale_by_gain(knob[amc_pkg::CSR_LAND_ROLL_GAIN],
                                              r.roll_error);
               o.throttle_cmd = amc_pkg::THROTTLE_LAND;
            end
            default: begin
               o.pitch_cmd = halve_command(r.balance_pitch);
               o.roll_cmd  = halve_command(r.balance_roll);
            end
         endcase
      end
      o.flight_mode         = st_mode;
      o.total_airborne_ms   = st_air_total;
      o.longest_airborne_ms = st_air_longest;
      o.hard_landing_count  = st_hard;
      o.good_landing_count  = st_good;
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic amc_pkg::req_type update_item(logic [31:0] stamp, logic air,
                                                    logic [15:0] conf, logic impact,
                                                    logic [15:0] peak);
      amc_pkg::req_type r;
      r = '0;
      r.func          = amc_pkg::FUNC_UPDATE;
      r.stamp_ms      = stamp;
      r.airborne_flag = air;
      r.confidence    = conf;
      r.impact_flag   = impact;
      r.peak_impact   = peak;
      // Junk in the command fields; an update must still return zero commands.
      r.pitch_error   = 16'sh7FFF;
      r.balance_roll  = 16'sh8000;
      return r;
   endfunction

   function automatic amc_pkg::req_type command_item(logic signed [15:0] perr,
                                                     logic signed [15:0] rerr,
                                                     logic signed [15:0] bpitch,
                                                     logic signed [15:0] broll);
      amc_pkg::req_type r;
      r = '0;
      r.func          = amc_pkg::FUNC_COMMAND;
      r.stamp_ms      = 32'hFFFF_FFFF;
      r.airborne_flag = 1'b1;
      r.confidence    = 16'hFFFF;
      r.pitch_error   = perr;
      r.roll_error    = rerr;
      r.balance_pitch = bpitch;
      r.balance_roll  = broll;
      return r;
   endfunction

   function automatic amc_pkg::rsp_type outcome(amc_pkg::mode_type m,
                                                logic signed [15:0] pitch,
                                                logic signed [15:0] roll,
                                                logic signed [15:0] throttle,
                                                logic tpulse, logic lpulse,
                                                logic [31:0] total, logic [31:0] longest,
                                                logic [31:0] hard, logic [31:0] good);
      amc_pkg::rsp_type o;
      o.flight_mode         = m;
      o.pitch_cmd           = pitch;
      o.roll_cmd            = roll;
      o.throttle_cmd        = throttle;
      o.takeoff_pulse       = tpulse;
      o.landing_pulse       = lpulse;
      o.total_airborne_ms   = total;
      o.longest_airborne_ms = longest;
      o.hard_landing_count  = hard;
      o.good_landing_count  = good;
      return o;
   endfunction

   // Mostly well-formed traffic steered by the shadow mode, plus some noise.
   function automatic amc_pkg::req_type next_random_item();
      amc_pkg::req_type r;
      logic [31:0]      wa;
      logic [31:0]      wb;
      logic [31:0]      wc;
      logic [31:0]      wd;
      logic [15:0]      thr;
      logic [16:0]      twice;
      int unsigned      pick;
      wa = $urandom;
      wb = $urandom;
      wc = $urandom;
      wd = $urandom;
      r.func          = wd[0];
      r.stamp_ms      = $urandom;
      r.airborne_flag = wd[1];
      r.confidence    = wc[15:0];
      r.impact_flag   = wd[2];
      r.peak_impact   = wc[31:16];
      r.pitch_error   = wa[15:0];
      r.roll_error    = wa[31:16];
      r.balance_pitch = wb[15:0];
      r.balance_roll  = wb[31:16];
      if ($urandom_range(99) < 15)
         return r;

      // Advance time: mostly small steps, sometimes past the longest hold,
      // now and then a jump anywhere (wrap included).
      pick = $urandom_range(99);
      if (pick < 60)
         clock_ms = clock_ms + $urandom_range(150);
      else if (pick < 85)
         clock_ms = clock_ms + $urandom_range(400);
      else if (pick < 95)
         clock_ms = clock_ms + $urandom_range(70000);
      else
         clock_ms = clock_ms + $urandom;
      r.stamp_ms = clock_ms;
      r.func     = ($urandom_range(99) < 40) ? amc_pkg::FUNC_COMMAND : amc_pkg::FUNC_UPDATE;
      if (r.func == amc_pkg::FUNC_UPDATE) begin
         case (st_mode)
            amc_pkg::MODE_GROUND: begin
               thr             = knob[amc_pkg::CSR_CONF_THRESHOLD];
               r.airborne_flag = ($urandom_range(99) < 70);
               if ($urandom_range(99) < 80 && thr != 16'hFFFF)
                  r.confidence = 16'($urandom_range(65535, thr + 1));
               else
                  r.confidence = 16'($urandom_range(thr, 0));
            end
            amc_pkg::MODE_AIR: begin
               if ($urandom_range(99) < 35) begin
                  r.airborne_flag = wd[3];
                  r.impact_flag   = wd[3] ? 1'b1 : wd[4];
               end else begin
                  r.airborne_flag = 1'b1;
                  r.impact_flag   = 1'b0;
               end
            end
            default: begin
               // Land the peak right on or just past the hard limit often.
               twice = {knob[amc_pkg::CSR_GRAVITY_LEVEL], 1'b0};
               case ($urandom_range(2))
                  0: r.peak_impact = twice[16] ? 16'hFFFF : twice[15:0];
                  1: begin
                     twice = twice + 17'd1;
                     r.peak_impact = twice[16] ? 16'hFFFF : twice[15:0];
                  end
                  default: ;
               endcase
            end
         endcase
      end
      return r;
   endfunction

   function automatic amc_pkg::cfg_type random_setting();
      amc_pkg::cfg_type c;
      c.air_pitch_gain       = 16'($urandom_range(65535));
      c.air_roll_gain        = 16'($urandom_range(65535));
      c.land_pitch_gain      = 16'($urandom_range(65535));
      c.land_roll_gain       = 16'($urandom_range(65535));
      c.landing_hold_ms      = 16'($urandom_range(600));
      c.settle_hold_ms       = 16'($urandom_range(600));
      c.confidence_threshold = 16'($urandom_range(65535));
      c.gravity_level        = 16'($urandom_range(40000));
      return c;
   endfunction

   // Present one transaction and hold it until taken. Call and return at a
   // falling edge; the caller either offers the next one or drops valid.
   task automatic offer(input amc_pkg::req_type item, input bit pinned,
                        input amc_pkg::rsp_type pin);
      int unsigned goal;
      goal = accepted + 1;
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      pin_valid   <= pinned;
      pin_rsp     <= pin;
      do
         @(negedge clock);
      while (accepted != goal);
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count)
         offer(next_random_item(), 1'b0, '0);
   endtask

   // Drain the unit, then write every control register.
   task automatic program_regs(input amc_pkg::cfg_type c);
      logic [15:0] vals [8];
      int          k;
      vals[amc_pkg::CSR_AIR_PITCH_GAIN]  = c.air_pitch_gain;
      vals[amc_pkg::CSR_AIR_ROLL_GAIN]   = c.air_roll_gain;
      vals[amc_pkg::CSR_LAND_PITCH_GAIN] = c.land_pitch_gain;
      vals[amc_pkg::CSR_LAND_ROLL_GAIN]  = c.land_roll_gain;
      vals[amc_pkg::CSR_LANDING_HOLD]    = c.landing_hold_ms;
      vals[amc_pkg::CSR_SETTLE_HOLD]     = c.settle_hold_ms;
      vals[amc_pkg::CSR_CONF_THRESHOLD]  = c.confidence_threshold;
      vals[amc_pkg::CSR_GRAVITY_LEVEL]   = c.gravity_level;
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      for (k = 0; k < 8; k++) begin
         csr_we    <= 1'b1;
         csr_index <= k[amc_pkg::CSR_INDEX_WIDTH-1:0];
         csr_wdata <= vals[k];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic flag_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("result %0d: %s expected 0x%0h, got 0x%0h",
                  delivered, field, want, got);
   endtask

   task automatic compare_result(input amc_pkg::rsp_type want,
                                 input amc_pkg::rsp_type got);
      if (got.flight_mode !== want.flight_mode)
         flag_field("flight_mode", want.flight_mode, got.flight_mode);
      if (got.pitch_cmd !== want.pitch_cmd)
         flag_field("pitch_cmd", want.pitch_cmd, got.pitch_cmd);
      if (got.roll_cmd !== want.roll_cmd)
         flag_field("roll_cmd", want.roll_cmd, got.roll_cmd);
      if (got.throttle_cmd !== want.throttle_cmd)
         flag_field("throttle_cmd", want.throttle_cmd, got.throttle_cmd);
      if (got.takeoff_pulse !== want.takeoff_pulse)
         flag_field("takeoff_pulse", want.takeoff_pulse, got.takeoff_pulse);
      if (got.landing_pulse !== want.landing_pulse)
         flag_field("landing_pulse", want.landing_pulse, got.landing_pulse);
      if (got.total_airborne_ms !== want.total_airborne_ms)
         flag_field("total_airborne_ms", want.total_airborne_ms, got.total_airborne_ms);
      if (got.longest_airborne_ms !== want.longest_airborne_ms)
         flag_field("longest_airborne_ms", want.longest_airborne_ms,
                    got.longest_airborne_ms);
      if (got.hard_landing_count !== want.hard_landing_count)
         flag_field("hard_landing_count", want.hard_landing_count,
                    got.hard_landing_count);
      if (got.good_landing_count !== want.good_landing_count)
         flag_field("good_landing_count", want.good_landing_count,
                    got.good_landing_count);
   endtask

   // Sample both channels and the register port at the rising edge. Predict
   // on acceptance first so a result can never overtake its own prediction.
   always @(posedge clock) begin : monitor
      amc_pkg::rsp_type want;
      if (!reset) begin
         if (csr_we)
            knob[csr_index] = csr_wdata;
         if (req_valid && !req_ready)
            stall_cycles++;
         if (req_valid && req_ready) begin
            want = advance_mode_machine(req_payload);
            if (pin_valid)
               want = pin_rsp;
            pending_results.push_back(want);
            accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            delivered++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result %0d arrived with nothing outstanding", delivered);
            end else begin
               compare_result(pending_results.pop_front(), rsp_payload);
            end
         end
         // Watchdog: count cycles in which neither channel moves.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls, one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            // Hold off long enough for the unit to fill and drop req_ready.
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 11);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      script_row_type   script[$];
      amc_pkg::cfg_type extreme_hi;
      amc_pkg::cfg_type extreme_lo;

      knob[amc_pkg::CSR_AIR_PITCH_GAIN]  = amc_pkg::RST_AIR_PITCH_GAIN;
      knob[amc_pkg::CSR_AIR_ROLL_GAIN]   = amc_pkg::RST_AIR_ROLL_GAIN;
      knob[amc_pkg::CSR_LAND_PITCH_GAIN] = amc_pkg::RST_LAND_PITCH_GAIN;
      knob[amc_pkg::CSR_LAND_ROLL_GAIN]  = amc_pkg::RST_LAND_ROLL_GAIN;
      knob[amc_pkg::CSR_LANDING_HOLD]    = amc_pkg::RST_LANDING_HOLD;
      knob[amc_pkg::CSR_SETTLE_HOLD]     = amc_pkg::RST_SETTLE_HOLD;
      knob[amc_pkg::CSR_CONF_THRESHOLD]  = amc_pkg::RST_CONF_THRESHOLD;
      knob[amc_pkg::CSR_GRAVITY_LEVEL]   = amc_pkg::RST_GRAVITY_LEVEL;
      st_mode        = amc_pkg::MODE_GROUND;
      st_entry_ms    = '0;
      st_takeoff_ms  = '0;
      st_air_total   = '0;
      st_air_longest = '0;
      st_hard        = '0;
      st_good        = '0;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      pin_valid   = 1'b0;
      pin_rsp     = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      calm        = 1'b0;
      hold_req    = 1'b0;
      clock_ms    = $urandom;

      // Directed script at reset settings. Hand-typed results where they are
      // obvious; gain products and halving go to the predictor.
      // Command in ground passes the balance commands straight through.
      script.push_back('{command_item(16'sh1111, 16'sh2222, 16'sh7FFF, 16'sh8000), 1'b1,
                         outcome(amc_pkg::MODE_GROUND, 16'sh7FFF, 16'sh8000,
                                 amc_pkg::THROTTLE_NONE, 0, 0, 0, 0, 0, 0)});
      // Confidence equal to the threshold does not take off.
      script.push_back('{update_item(32'd10, 1'b1, 16'd45875, 1'b0, 16'd0), 1'b1,
                         outcome(amc_pkg::MODE_GROUND, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      // One above the threshold does.
      script.push_back('{update_item(32'd1000, 1'b1, 16'd45876, 1'b0, 16'd0), 1'b1,
                         outcome(amc_pkg::MODE_AIR, 0, 0, 0, 1, 0, 0, 0, 0, 0)});
      script.push_back('{command_item(16'sh7FFF, 16'sh8000, 16'sh1234, 16'sh4321), 1'b0,
                         amc_pkg::rsp_type'('0)});
      // Still airborne and no impact: stay.
      script.push_back('{update_item(32'd1200, 1'b1, 16'd0, 1'b0, 16'hFFFF), 1'b1,
                         outcome(amc_pkg::MODE_AIR, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      // Impact while still flagged airborne lands after 500 ms.
      script.push_back('{update_item(32'd1500, 1'b1, 16'hFFFF, 1'b1, 16'd0), 1'b1,
                         outcome(amc_pkg::MODE_LAND, 0, 0, 0, 0, 1, 500, 500, 0, 0)});
      script.push_back('{command_item(16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000), 1'b0,
                         amc_pkg::rsp_type'('0)});
      // Exactly the landing hold: not yet.
      script.push_back('{update_item(32'd1700, 1'b0, 16'd0, 1'b0, 16'd5022), 1'b1,
                         outcome(amc_pkg::MODE_LAND, 0, 0, 0, 0, 0, 500, 500, 0, 0)});
      // One past the hold, peak exactly twice gravity: good landing.
      script.push_back('{update_item(32'd1701, 1'b0, 16'd0, 1'b0, 16'd5022), 1'b1,
                         outcome(amc_pkg::MODE_RECOVER, 0, 0, 0, 0, 0, 500, 500, 0, 1)});
      script.push_back('{command_item(16'sh0000, 16'sh0000, 16'shFFFF, 16'sh7FFF), 1'b0,
                         amc_pkg::rsp_type'('0)});
      script.push_back('{command_item(16'sh0000, 16'sh0000, 16'sh8000, 16'sh0001), 1'b0,
                         amc_pkg::rsp_type'('0)});
      // Exactly the settle hold, then one past it.
      script.push_back('{update_item(32'd2001, 1'b1, 16'hFFFF, 1'b0, 16'd0), 1'b0,
                         amc_pkg::rsp_type'('0)});
      script.push_back('{update_item(32'd2002, 1'b1, 16'hFFFF, 1'b0, 16'd0), 1'b0,
                         amc_pkg::rsp_type'('0)});
      // Full confidence but not flagged airborne: stay on the ground.
      script.push_back('{update_item(32'd3000, 1'b0, 16'hFFFF, 1'b0, 16'd0), 1'b0,
                         amc_pkg::rsp_type'('0)});
      // Take off just before the timestamp wraps, land just after it.
      script.push_back('{update_item(32'hFFFF_FF00, 1'b1, 16'hFFFF, 1'b0, 16'd0), 1'b0,
                         amc_pkg::rsp_type'('0)});
      script.push_back('{command_item(16'sh0000, 16'shFFFF, 16'sh0000, 16'sh0000), 1'b0,
                         amc_pkg::rsp_type'('0)});
      script.push_back('{update_item(32'h0000_0100, 1'b0, 16'd0, 1'b0, 16'd0), 1'b0,
                         amc_pkg::rsp_type'('0)});
      // One above twice gravity: hard landing.
      script.push_back('{update_item(32'h0000_01C9, 1'b0, 16'd0, 1'b0, 16'd5023), 1'b0,
                         amc_pkg::rsp_type'('0)});
      script.push_back('{update_item(32'h0000_02F6, 1'b0, 16'd0, 1'b1, 16'hFFFF), 1'b0,
                         amc_pkg::rsp_type'('0)});

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         offer(script[i].item, script[i].pinned, script[i].pin);
      run_random(80);

      // Every gain at full scale, zero holds, zero threshold and gravity.
      extreme_hi = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0};
      program_regs(extreme_hi);
      run_random(20);
      // Starve the result side while the sender keeps pushing.
      hold_req = 1'b1;
      run_random(70);

      // Zero gains, longest holds, unreachable threshold, top gravity.
      extreme_lo = '{16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      program_regs(extreme_lo);
      run_random(40);

      // Two random settings; the first starts with a stretch of no idling.
      program_regs(random_setting());
      calm = 1'b1;
      run_random(70);
      calm = 1'b0;
      run_random(30);
      program_regs(random_setting());
      run_random(100);

      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      // Let any stray result show up before the verdict.
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Ran %0d transactions (%0d commands) over five register settings.",
               accepted, n_commands);
      $display("Saw %0d takeoffs, %0d landings (%0d hard, %0d good), %0d stalled cycles.",
               n_takeoffs, n_landings, st_hard, st_good, stall_cycles);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== airborne_mode_controller_unit.f =====
src/amc_pkg.sv
src/amc_mode_core.sv
src/amc_cmd_gen.sv
src/airborne_mode_controller_unit.sv
tb/tb_airborne_mode_controller_unit.sv
